>>> design/assert_macros.svh
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every clock edge out of reset
`define ASRT_ALWAYS(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// ante at an edge implies cons at the same edge
`define ASRT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// ante at an edge implies cons at the next edge
`define ASRT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/spc_pkg.sv
`timescale 1ns / 1ps
package spc_pkg;

  localparam int unsigned WordW  = 56;
  localparam int unsigned ShiftW = 6;
  localparam int unsigned CntW   = 3;
  localparam int unsigned NumW   = 4;

  localparam logic [NumW-1:0] EncGroup = 4'd7;
  localparam logic [NumW-1:0] DecGroup = 4'd8;
  localparam logic [NumW-1:0] EncFull  = 4'd8;
  localparam logic [NumW-1:0] DecFull  = 4'd7;

  localparam logic ModeEncode = 1'b0;
  localparam logic ModeDecode = 1'b1;

  typedef struct packed {
    logic [7:0] data_in;
    logic       last_in;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] data_out;
    logic       run_end;
    logic       buffer_end;
  } out_beat_t;

  // one finished group handed from front to back
  typedef struct packed {
    logic [WordW-1:0] word;
    logic [NumW-1:0]  num;
    logic             last;
    logic             mode;
  } grp_t;

endpackage

>>> design/spc_front.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module spc_front import spc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cfg_we,
  input  logic     cfg_data,
  input  logic     in_valid,
  input  in_beat_t in_beat,
  output logic     grp_valid,
  output grp_t     grp
);

  logic             mode_r, mode_nxt;
  logic [WordW-1:0] word_r, word_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;

  logic [ShiftW-1:0] shamt;
  logic [WordW-1:0]  ins;
  logic [WordW-1:0]  word_new;
  logic [NumW-1:0]   cnt_inc;
  logic [NumW-1:0]   num;
  logic              emit;

  always_comb begin
    if (mode_r == ModeDecode) begin
      shamt = {cnt_r, 3'b000} - {3'b000, cnt_r};
    end else begin
      shamt = {cnt_r, 3'b000};
    end
    // decode bit 7 of the eighth symbol falls off the 56-bit word
    ins      = {{(WordW-8){1'b0}}, in_beat.data_in} << shamt;
    word_new = word_r | ins;
    cnt_inc  = {1'b0, cnt_r} + 4'd1;
    emit     = 1'b0;
    num      = '0;
    if (mode_r == ModeDecode) begin
      if (cnt_inc == DecGroup) begin
        emit = 1'b1;
        num  = DecFull;
      end else if (in_beat.last_in) begin
        emit = 1'b1;
        num  = cnt_inc - 4'd1;
      end
    end else begin
      if (cnt_inc == EncGroup) begin
        emit = 1'b1;
        num  = EncFull;
      end else if (in_beat.last_in) begin
        emit = 1'b1;
        num  = cnt_inc + 4'd1;
      end
    end
  end

  always_comb begin
    mode_nxt = mode_r;
    word_nxt = word_r;
    cnt_nxt  = cnt_r;
    if (cfg_we) begin
      mode_nxt = cfg_data;
      word_nxt = '0;
      cnt_nxt  = '0;
    end else if (in_valid) begin
      if (emit) begin
        word_nxt = '0;
        cnt_nxt  = '0;
      end else begin
        word_nxt = word_new;
        cnt_nxt  = cnt_inc[CntW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= ModeEncode;
      word_r <= '0;
      cnt_r  <= '0;
    end else begin
      mode_r <= mode_nxt;
      word_r <= word_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // a decode group of one symbol yields nothing
  assign grp_valid = in_valid && !cfg_we && emit && (num != '0);
  assign grp.word  = word_new;
  assign grp.num   = num;
  assign grp.last  = in_beat.last_in;
  assign grp.mode  = mode_r;

  `ASRT_IMPLY(a_enc_cnt, clk, rst_n, mode_r == ModeEncode, cnt_r != 3'd7, "encode count overran")
  `ASRT_NEXT(a_cfg_clr, clk, rst_n, cfg_we, cnt_r == '0 && word_r == '0, "config did not clear")

endmodule

>>> design/spc_fifo.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module spc_fifo import spc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  grp_t wr_grp,
  output logic full,
  input  logic rd_en,
  output logic rd_valid,
  output grp_t rd_grp
);

  grp_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_wr, do_rd;

  assign full     = (count_r == 2'd2);
  assign rd_valid = (count_r != 2'd0);
  assign rd_grp   = mem_r[rd_ptr_r];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_wr;
    rd_ptr_nxt = rd_ptr_r ^ do_rd;
    count_nxt  = count_r + {1'b0, do_wr} - {1'b0, do_rd};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_grp;
    end
  end

  `ASRT_ALWAYS(a_cnt_max, clk, rst_n, count_r != 2'd3, "queue count overran")
  `ASRT_IMPLY(a_no_drop, clk, rst_n, wr_en, !full, "group dropped on full queue")

endmodule

>>> design/spc_back.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module spc_back import spc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      grp_valid,
  input  grp_t      grp,
  output logic      grp_take,
  output logic      empty,
  input  logic      pop,
  output out_beat_t out_beat
);

  logic [WordW-1:0] word_r, word_nxt;
  logic [NumW-1:0]  left_r, left_nxt;
  logic             last_r, last_nxt;
  logic             mode_r, mode_nxt;
  logic             advance;

  assign empty    = (left_r == '0);
  assign advance  = pop && !empty;
  assign grp_take = grp_valid && (empty || (advance && left_r == 4'd1));

  always_comb begin
    word_nxt = word_r;
    left_nxt = left_r;
    last_nxt = last_r;
    mode_nxt = mode_r;
    if (grp_take) begin
      word_nxt = grp.word;
      left_nxt = grp.num;
      last_nxt = grp.last;
      mode_nxt = grp.mode;
    end else if (advance) begin
      left_nxt = left_r - 4'd1;
      if (mode_r == ModeDecode) begin
        word_nxt = word_r >> 8;
      end else begin
        word_nxt = word_r >> 7;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
    end else begin
      left_r <= left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    last_r <= last_nxt;
    mode_r <= mode_nxt;
  end

  assign out_beat.data_out   = (mode_r == ModeDecode) ? word_r[7:0] : {1'b0, word_r[6:0]};
  assign out_beat.run_end    = (left_r == 4'd1);
  assign out_beat.buffer_end = last_r && (left_r == 4'd1);

  `ASRT_IMPLY(a_load_nz, clk, rst_n, grp_take, grp.num != '0 && grp.num <= EncFull, "bad group size")
  `ASRT_ALWAYS(a_left_max, clk, rst_n, left_r <= EncFull, "result count overran")

endmodule

>>> design/seven_bit_pack_codec.sv
// A finished group is registered in the group queue, then loaded into the output stage registers.
// Throughput: one input beat per cycle unless the queue is full, and one result per cycle while
// pop is held; encode gives 8 results per 7 inputs, so the single result port sets input rate.
// A 2-entry group queue sits between the gathering front and the shifting output stage.
// Reset: synchronous, active low; clears mode to encode, the partial group and all queues.
`timescale 1ns / 1ps
module seven_bit_pack_codec import spc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic      cfg_data,
  input  logic      push,
  output logic      full,
  input  in_beat_t  in_data,
  output logic      empty,
  input  logic      pop,
  output out_beat_t out_data
);

  logic grp_wr;
  grp_t grp_in;
  logic grp_rd_valid;
  grp_t grp_out;
  logic grp_take;
  logic q_full;

  assign full = q_full;

  spc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_valid  (push && !q_full),
    .in_beat   (in_data),
    .grp_valid (grp_wr),
    .grp       (grp_in)
  );

  spc_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (grp_wr),
    .wr_grp   (grp_in),
    .full     (q_full),
    .rd_en    (grp_take),
    .rd_valid (grp_rd_valid),
    .rd_grp   (grp_out)
  );

  spc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .grp_valid (grp_rd_valid),
    .grp       (grp_out),
    .grp_take  (grp_take),
    .empty     (empty),
    .pop       (pop),
    .out_beat  (out_data)
  );

endmodule
